FILE: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue unit and its cells.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned VALUE_W       = 31;
   localparam int unsigned OPCODE_W      = 3;
   localparam int unsigned STATUS_W      = 2;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DRAIN      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  item_value;
      logic                last_item;
   } rsp_type;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic load_back;
   } cell_ctl_type;

endpackage

FILE: sv/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the deque row: takes its lower neighbor, its upper neighbor or
// the pushed word, or holds.
// ----------------------------------------------------------------------------
module dq_cell #(
   parameter int unsigned CNT_W = 7,
   parameter int unsigned INDEX = 0
) (
   input  logic                          clock,
   input  dq_pkg::cell_ctl_type          ctl,
   input  logic [CNT_W-1:0]              cnt,
   input  logic [dq_pkg::VALUE_W-1:0]    push_value,
   input  logic [dq_pkg::VALUE_W-1:0]    prev_value,
   input  logic [dq_pkg::VALUE_W-1:0]    next_value,
   output logic [dq_pkg::VALUE_W-1:0]    value
);
   import dq_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift_up) begin
         value_in = prev_value;
      end else if (ctl.shift_down) begin
         value_in = next_value;
      end else if (ctl.load_back && (cnt == CNT_W'(INDEX))) begin
         value_in = push_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: sv/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque held in a row of shifting cells; front is cell zero.
// ----------------------------------------------------------------------------
// Push and pop: one item per cycle while the output is free; result registered.
// Drain of N entries: acceptance enters S_DRAIN, which shifts one entry per
// cycle from cell zero while the output is free; commands wait for the last.
// Output register sets throughput: one result per cycle unless rsp_ready stalls.
// Reset clears the fill count, state and output valid; cell contents are kept.
module double_ended_queue_unit #(
   parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_DRAIN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   cell_ctl_type       ctl;
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic               out_free;
   logic               req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.item_value = '0;
                     rsp_in.last_item  = 1'b1;
                     if (cnt_ff == CNT_W'(DEPTH)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        rsp_in.status = STATUS_OK;
                        cnt_in        = cnt_ff + 1'b1;
                        ctl.shift_up  = (req_data.opcode == OP_PUSH_FRONT);
                        ctl.load_back = (req_data.opcode == OP_PUSH_BACK);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.item_value = '0;
                     rsp_in.last_item  = 1'b1;
                     if (cnt_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_in.status  = STATUS_OK;
                        cnt_in         = cnt_ff - 1'b1;
                        ctl.shift_down = (req_data.opcode == OP_POP_FRONT);
                     end
                  end
                  OP_DRAIN: begin
                     if (cnt_ff != '0) begin
                        state_in = S_DRAIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = STATUS_OK;
               rsp_in.item_value = cell_value[0];
               rsp_in.last_item  = (cnt_ff == CNT_W'(1));
               ctl.shift_down    = 1'b1;
               cnt_in            = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] prev_value;
      logic [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = req_data.push_value;
      end else begin : g_mid
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      dq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cnt        (cnt_ff),
         .push_value (req_data.push_value),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

endmodule
